@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_AT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/core/ccrt_pkg.sv @@
// ----------------------------------------------------------------------------
// ccrt_pkg
// Types, constants and helpers of the cyclic Catmull-Rom trajectory core
// ----------------------------------------------------------------------------
package ccrt_pkg;

	// field widths
	localparam int COORD_W = 32;
	localparam int SPEED_W = 24;
	localparam int TIME_W  = 24;
	localparam int PARAM_W = 16;
	localparam int COUNT_W = 5;

	// spline accumulator, wide enough for every Horner partial sum
	localparam int ACC_W  = 40;
	localparam int PROD_W = ACC_W + PARAM_W + 1;

	// configuration port
	localparam int ADDR_W    = 3;
	localparam int REG_IDX_W = 1;
	localparam int APB_W     = 32;
	localparam logic [REG_IDX_W-1:0] REG_SPEED = 1'b0;
	localparam logic [SPEED_W-1:0]   SPEED_RESET = 24'h008000;

	// request codes
	localparam logic REQ_STORE = 1'b0;
	localparam logic REQ_TICK  = 1'b1;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [ACC_W-1:0]   acc_t;
	typedef logic signed [PROD_W-1:0]  prod_t;

	typedef struct packed {
		coord_t z;
		coord_t y;
		coord_t x;
	} point_t;

	localparam coord_t COORD_MAX = 32'sh7FFF_FFFF;
	localparam coord_t COORD_MIN = 32'sh8000_0000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_FETCH,
		ST_LAST,
		ST_COEF,
		ST_MUL,
		ST_ADD,
		ST_DONE
	} ccrt_state_t;

	// sign extend a coordinate into the accumulator width
	function automatic acc_t ext_coord(coord_t p);
		return ACC_W'(p);
	endfunction

	// floor halve and saturate to a coordinate
	function automatic coord_t sat_half(acc_t v);
		logic [ACC_W-2:0] h;
		h = v[ACC_W-1:1];
		if (!h[ACC_W-2] && (|h[ACC_W-2:COORD_W-1]))
			return COORD_MAX;
		if (h[ACC_W-2] && !(&h[ACC_W-2:COORD_W-1]))
			return COORD_MIN;
		return coord_t'(h[COORD_W-1:0]);
	endfunction

endpackage

@@ rtl/core/ccrt_if.sv @@
// ----------------------------------------------------------------------------
// ccrt_if
// Valid/ready channels for requests and results of the trajectory core
// ----------------------------------------------------------------------------
interface ccrt_req_if import ccrt_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               req_type;
	coord_t             point_x;
	coord_t             point_y;
	coord_t             point_z;
	logic [TIME_W-1:0]  delta_time;

	modport source (output valid, req_type, point_x, point_y, point_z, delta_time,
		input ready);
	modport sink (input valid, req_type, point_x, point_y, point_z, delta_time,
		output ready);
endinterface

interface ccrt_res_if import ccrt_pkg::*; ();
	logic               valid;
	logic               ready;
	coord_t             pos_x;
	coord_t             pos_y;
	coord_t             pos_z;
	logic               store_dropped;
	logic [COUNT_W-1:0] stored_count;

	modport source (output valid, pos_x, pos_y, pos_z, store_dropped, stored_count,
		input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, store_dropped, stored_count,
		output ready);
endinterface

@@ rtl/core/cyclic_catmull_rom_trajectory_core.sv @@
// ----------------------------------------------------------------------------
// cyclic_catmull_rom_trajectory_core
// Control point table and uniform Catmull-Rom evaluator on a cyclic path
// ----------------------------------------------------------------------------
// channel  | dir | transfer
// ---------+-----+----------------------------------------------------------
// req      | in  | store a control point, or a tick with delta_time
// res      | out | position, store_dropped, stored_count, one per request
// apb      | in  | trajectory_speed at byte address 0, pready tied high
//
// A tick with at least one point goes from transfer to result through
// four reads of the single point memory port, then three Horner steps of a
// multiply state and an add state per axis. Stores and ticks with no points
// skip both. One request is in flight at a time; the next one transfers
// while the previous result waits in the output register. Reset clears the
// point count, segment index and curve parameter; no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cyclic_catmull_rom_trajectory_core import ccrt_pkg::*; #(
	parameter int MAX_POINTS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [APB_W-1:0]  pwdata,
	output logic [APB_W-1:0]  prdata,
	output logic              pready,
	ccrt_req_if.sink          req,
	ccrt_res_if.source        res
);

	localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int NW = $clog2(MAX_POINTS + 1);

	ccrt_state_t state_q, state_d;

	// architectural state
	logic [NW-1:0]      point_total_q;
	logic [IW-1:0]      seg_q;
	logic [PARAM_W-1:0] cp_q;
	logic [SPEED_W-1:0] speed_q;

	// captured request
	logic              type_q;
	point_t            item_pt_q;
	logic [TIME_W-1:0] delta_q;

	// point memory
	point_t            mem [MAX_POINTS];
	point_t            rd_data_s1;
	logic              rd_en_s1;
	logic [1:0]        rd_slot_s1;

	// fetch and Horner sequencing
	logic [IW-1:0]     idx_q [4];
	logic [1:0]        rd_cnt_q;
	logic [1:0]        step_q;
	point_t            pt_q [4];
	acc_t              a_q [3];
	acc_t              b_q [3];
	acc_t              c_q [3];
	acc_t              acc_q [3];
	prod_t             prod_s1 [3];
	logic [SPEED_W+TIME_W-1:0] inc_s1;
	logic              dropped_q;

	// output register
	logic               out_valid_q;
	coord_t             pos_x_q, pos_y_q, pos_z_q;
	logic               drop_out_q;
	logic [COUNT_W-1:0] count_out_q;

	// control strobes
	logic in_ready, mem_we, rd_en, load_out, adv_en;
	logic full;
	logic [REG_IDX_W-1:0] reg_idx;
	logic cfg_we;

	// configuration port
	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg_we  = psel && penable && pwrite && (reg_idx == REG_SPEED);
	assign prdata  = (reg_idx == REG_SPEED) ? APB_W'(speed_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= SPEED_RESET;
		end else if (cfg_we) begin
			speed_q <= pwdata[SPEED_W-1:0];
		end
	end

	assign full = (point_total_q == NW'(MAX_POINTS));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req.valid)
					state_d = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				if (type_q == REQ_STORE || point_total_q == '0)
					state_d = ST_DONE;
				else
					state_d = ST_FETCH;
			end
			ST_FETCH: begin
				if (rd_cnt_q == 2'd3)
					state_d = ST_LAST;
			end
			ST_LAST:  state_d = ST_COEF;
			ST_COEF:  state_d = ST_MUL;
			ST_MUL:   state_d = ST_ADD;
			ST_ADD: begin
				if (step_q == 2'd2)
					state_d = ST_DONE;
				else
					state_d = ST_MUL;
			end
			ST_DONE: begin
				if (!out_valid_q || res.ready)
					state_d = ST_IDLE;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_ready = 1'b0;
		mem_we   = 1'b0;
		rd_en    = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE:     in_ready = 1'b1;
			ST_DISPATCH: mem_we   = (type_q == REQ_STORE) && !full;
			ST_FETCH:    rd_en    = 1'b1;
			ST_DONE:     load_out = !out_valid_q || res.ready;
			default: begin
			end
		endcase
	end

	assign adv_en = load_out && (type_q == REQ_TICK) && (point_total_q >= NW'(2));
	assign req.ready = in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// capture the request on transfer
	always_ff @(posedge clk) begin
		if (req.valid && in_ready) begin
			type_q      <= req.req_type;
			item_pt_q.x <= req.point_x;
			item_pt_q.y <= req.point_y;
			item_pt_q.z <= req.point_z;
			delta_q     <= req.delta_time;
		end
	end

	// neighbor indices of the current segment, cyclic over the point count
	logic [NW-1:0] i0w, i1w, i2w, i3w;
	always_comb begin
		i1w = (NW'(seg_q) < point_total_q) ? NW'(seg_q) : '0;
		i0w = (i1w == '0) ? point_total_q - NW'(1) : i1w - NW'(1);
		i2w = (i1w + NW'(1) == point_total_q) ? '0 : i1w + NW'(1);
		i3w = (i2w + NW'(1) == point_total_q) ? '0 : i2w + NW'(1);
	end

	// dispatch: indices, parameter increment, store flag
	always_ff @(posedge clk) begin
		if (state_q == ST_DISPATCH) begin
			idx_q[0]  <= i0w[IW-1:0];
			idx_q[1]  <= i1w[IW-1:0];
			idx_q[2]  <= i2w[IW-1:0];
			idx_q[3]  <= i3w[IW-1:0];
			inc_s1    <= speed_q * delta_q;
			dropped_q <= (type_q == REQ_STORE) && full;
		end
	end

	// point memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[point_total_q[IW-1:0]] <= item_pt_q;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data_s1 <= mem[idx_q[rd_cnt_q]];
	end

	// read bookkeeping; accesses never overlap, so no forwarding is needed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_en_s1   <= 1'b0;
			rd_slot_s1 <= '0;
			rd_cnt_q   <= '0;
			step_q     <= '0;
		end else begin
			rd_en_s1   <= rd_en;
			rd_slot_s1 <= rd_cnt_q;
			if (state_q == ST_DISPATCH)
				rd_cnt_q <= '0;
			else if (rd_en)
				rd_cnt_q <= rd_cnt_q + 2'd1;
			if (state_q == ST_COEF)
				step_q <= '0;
			else if (state_q == ST_ADD)
				step_q <= step_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en_s1)
			pt_q[rd_slot_s1] <= rd_data_s1;
	end

	// per axis control point views
	acc_t p0 [3], p1 [3], p2 [3], p3 [3];
	always_comb begin
		p0[0] = ext_coord(pt_q[0].x);
		p1[0] = ext_coord(pt_q[1].x);
		p2[0] = ext_coord(pt_q[2].x);
		p3[0] = ext_coord(pt_q[3].x);
		p0[1] = ext_coord(pt_q[0].y);
		p1[1] = ext_coord(pt_q[1].y);
		p2[1] = ext_coord(pt_q[2].y);
		p3[1] = ext_coord(pt_q[3].y);
		p0[2] = ext_coord(pt_q[0].z);
		p1[2] = ext_coord(pt_q[1].z);
		p2[2] = ext_coord(pt_q[2].z);
		p3[2] = ext_coord(pt_q[3].z);
	end

	// coefficient to add after each Horner multiply
	acc_t coef_sel [3];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			case (step_q)
				2'd0:    coef_sel[k] = c_q[k];
				2'd1:    coef_sel[k] = b_q[k];
				default: coef_sel[k] = a_q[k];
			endcase
		end
	end

	// coefficients, then Horner multiply and add per axis
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			if (state_q == ST_COEF) begin
				a_q[k]   <= p1[k] <<< 1;
				b_q[k]   <= p2[k] - p0[k];
				c_q[k]   <= (p0[k] <<< 1) - ((p1[k] <<< 2) + p1[k]) + (p2[k] <<< 2) - p3[k];
				acc_q[k] <= ((p1[k] - p2[k]) <<< 1) + (p1[k] - p2[k]) + p3[k] - p0[k];
			end else if (state_q == ST_MUL) begin
				prod_s1[k] <= acc_q[k] * $signed({1'b0, cp_q});
			end else if (state_q == ST_ADD) begin
				acc_q[k] <= acc_t'(prod_s1[k][ACC_W+PARAM_W-1:PARAM_W]) + coef_sel[k];
			end
		end
	end

	// count, segment index and curve parameter
	logic [COORD_W:0] param_sum;
	assign param_sum = {{(COORD_W-PARAM_W+1){1'b0}}, cp_q}
		+ {1'b0, inc_s1[SPEED_W+TIME_W-1:PARAM_W]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_total_q <= '0;
			seg_q         <= '0;
			cp_q          <= '0;
		end else begin
			if (mem_we)
				point_total_q <= point_total_q + NW'(1);
			if (adv_en) begin
				if (|param_sum[COORD_W:PARAM_W]) begin
					cp_q  <= '0;
					seg_q <= idx_q[2];
				end else begin
					cp_q  <= param_sum[PARAM_W-1:0];
				end
			end
		end
	end

	// output register
	logic [NW+COUNT_W-1:0] count_ext;
	logic                  pos_live;
	assign count_ext = {{COUNT_W{1'b0}}, point_total_q};
	assign pos_live  = (type_q == REQ_TICK) && (point_total_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			pos_x_q     <= pos_live ? sat_half(acc_q[0]) : '0;
			pos_y_q     <= pos_live ? sat_half(acc_q[1]) : '0;
			pos_z_q     <= pos_live ? sat_half(acc_q[2]) : '0;
			drop_out_q  <= dropped_q;
			count_out_q <= count_ext[COUNT_W-1:0];
		end
	end

	assign res.valid         = out_valid_q;
	assign res.pos_x         = pos_x_q;
	assign res.pos_y         = pos_y_q;
	assign res.pos_z         = pos_z_q;
	assign res.store_dropped = drop_out_q;
	assign res.stored_count  = count_out_q;

	// checks
	`ASSERT_AT(a_total_bound, clk, arst_n, point_total_q <= NW'(MAX_POINTS))
	`ASSERT_AT(a_seg_in_range, clk, arst_n, (point_total_q < NW'(2)) || (NW'(seg_q) < point_total_q))
	`ASSERT_NEXT(a_store_grows, clk, arst_n, mem_we, point_total_q == $past(point_total_q) + NW'(1))
	`ASSERT_AT(a_write_not_full, clk, arst_n, !mem_we || !full)

endmodule
